// ===== hdl/tcfp_pkg.sv =====
// ============================================================================
// Tilt-compensated floor projection: shared types and constants
// Widths of the fixed datapath fields, register map, controller states and
// the command and status bundles that join the controller and the datapath.
// ============================================================================
package tcfp_pkg;

    // Fixed field widths
    localparam int D_W    = 9;   // signed accelerometer offset
    localparam int SUM_W  = 18;  // sum of three squared offsets
    localparam int SQ_N_W = 50;  // square root operand, sum shifted up by 32
    localparam int L_W    = 25;  // vector length, square root result
    localparam int V_W    = 28;  // signed camera ray component, Q12.16
    localparam int W_W    = 29;  // signed rotated ray component, Q13.16
    localparam int DEN_W  = 36;  // divisor width of the shared divider
    localparam int FH_W   = 16;  // floor height
    localparam int PADDR_W = 3;

    localparam int SQ_SHIFT = 32;

    // Camera model
    localparam logic signed [11:0]    PIX_CX    = 12'sd512;
    localparam logic signed [11:0]    PIX_CY    = 12'sd384;
    localparam logic signed [V_W-1:0] NEG_CAM_K = -28'sd93920134;

    // Register map and reset values
    localparam logic [PADDR_W-1:0] ADDR_FLOOR_HEIGHT = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_ACCEL_ZERO   = 3'd4;
    localparam logic [15:0]        FH_RESET          = 16'd256;
    localparam logic [7:0]         AZ_RESET          = 8'd118;

    // Item kinds
    localparam logic CMD_ACCEL = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_UNIT_WRITE,
        ST_FALLBACK,
        ST_SIDE_LOAD,
        ST_CROSS_A,
        ST_CROSS_B,
        ST_CROSS_WRITE,
        ST_MAC,
        ST_W_WRITE,
        ST_PROJ_START,
        ST_PROJ_WAIT,
        ST_PROJ_WRITE,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_ACCEL,
        OP_LOAD_POINT,
        OP_SQ,
        OP_SQRT_START,
        OP_SQRT_STEP,
        OP_DIV_UNIT_START,
        OP_DIV_PROJ_START,
        OP_DIV_STEP,
        OP_UNIT_WRITE,
        OP_FALLBACK,
        OP_SIDE_LOAD,
        OP_CROSS_A,
        OP_CROSS_B,
        OP_CROSS_WRITE,
        OP_MAC,
        OP_W_WRITE,
        OP_PROJ_WRITE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
        logic [1:0] row;
    } dp_cmd_t;

    typedef struct packed {
        logic sum_zero;
        logic sqrt_busy;
        logic div_busy;
        logic horizon;
    } dp_stat_t;

endpackage

// ===== hdl/tcfp_datapath.sv =====
// ============================================================================
// Tilt-compensated floor projection: datapath
// Rotation matrix, one shared signed multiplier with accumulator, a
// two-bits-per-step square root unit and a one-bit-per-step restoring divider.
// ============================================================================
module tcfp_datapath #(
    parameter int ROT_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcfp_pkg::dp_cmd_t    cmd,
    input  logic [7:0]           accel_x,
    input  logic [7:0]           accel_y,
    input  logic [7:0]           accel_z,
    input  logic [9:0]           pixel_x,
    input  logic [9:0]           pixel_y,
    input  logic [15:0]          floor_height,
    input  logic [7:0]           accel_zero,
    output tcfp_pkg::dp_stat_t   stat,
    output logic signed [31:0]   ground_x,
    output logic signed [31:0]   ground_y,
    output logic                 at_horizon
);
    import tcfp_pkg::*;

    localparam int F      = ROT_FRAC_BITS;
    localparam int O      = OUT_FRAC_BITS;
    localparam int RW     = F + 2;
    localparam int MA     = (RW > FH_W + 1) ? RW : FH_W + 1;
    localparam int MB     = (RW > W_W + 1) ? RW : W_W + 1;
    localparam int PW     = MA + MB;
    localparam int AW     = PW + 2;
    localparam int NUMW_U = F + 25;
    localparam int NUMW_P = 45 + O;
    localparam int NUMW   = ((NUMW_U > NUMW_P) ? NUMW_U : NUMW_P) + 1;
    localparam int CW     = $clog2(NUMW + 1);

    localparam logic signed [RW-1:0] ROT_ONE = {2'b01, {F{1'b0}}};

    // State and working registers
    logic signed [RW-1:0]  rot_reg [9];
    logic signed [D_W-1:0] d_reg [3];
    logic signed [D_W-1:0] vec_reg [3];
    logic [9:0]            px_reg;
    logic [9:0]            py_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [SQ_N_W-1:0]     sq_n_reg;
    logic [SQ_N_W-1:0]     sq_r_reg;
    logic [SQ_N_W-1:0]     sq_b_reg;
    logic [NUMW-1:0]       num_reg;
    logic [NUMW-1:0]       quo_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [CW-1:0]         cnt_reg;
    logic signed [W_W-1:0] w_reg [3];
    logic signed [31:0]    gx_reg;
    logic signed [31:0]    gy_reg;

    // Combinational signals
    logic [3:0]            rix;
    logic [1:0]            ci;
    logic [1:0]            cj;
    logic signed [11:0]    dx;
    logic signed [11:0]    dy;
    logic signed [V_W-1:0] v_vec [3];
    logic signed [MA-1:0]  mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic [AW-1:0]         acc_mag;
    logic [AW-1:0]         rnd_mag;
    logic [AW-1:0]         clamp_mag;
    logic [SQ_N_W-1:0]     sq_rb;
    logic [DEN_W:0]        trial;
    logic [DEN_W:0]        diff;
    logic                  ge;
    logic [D_W-1:0]        vec_mag;
    logic [W_W-1:0]        wk_mag;
    logic [W_W-1:0]        w2_mag;
    logic [DEN_W-1:0]      proj_den;
    logic [NUMW-1:0]       unit_t;
    logic signed [RW-1:0]  unit_val;
    logic signed [31:0]    proj_val;
    logic                  proj_neg;
    logic                  horizon;

    // Index arithmetic
    always_comb
    begin
        rix = {2'b00, cmd.row} * 4'd3 + {2'b00, cmd.idx};
        unique case (cmd.idx)
            2'd0:
            begin
                ci = 2'd1;
                cj = 2'd2;
            end
            2'd1:
            begin
                ci = 2'd2;
                cj = 2'd0;
            end
            default:
            begin
                ci = 2'd0;
                cj = 2'd1;
            end
        endcase
    end

    // Camera ray in Q12.16
    always_comb
    begin
        dx       = PIX_CX - $signed({2'b00, px_reg});
        dy       = $signed({2'b00, py_reg}) - PIX_CY;
        v_vec[0] = {dx, 16'b0};
        v_vec[1] = NEG_CAM_K;
        v_vec[2] = {dy, 16'b0};
    end

    // Magnitudes used by several operations
    always_comb
    begin
        vec_mag  = vec_reg[cmd.idx][D_W-1] ? D_W'(-vec_reg[cmd.idx]) : D_W'(vec_reg[cmd.idx]);
        wk_mag   = w_reg[cmd.idx][W_W-1] ? W_W'(-w_reg[cmd.idx]) : W_W'(w_reg[cmd.idx]);
        w2_mag   = w_reg[2][W_W-1] ? W_W'(-w_reg[2]) : W_W'(w_reg[2]);
        proj_den = DEN_W'({w2_mag[W_W-2:0], 8'b0});
        horizon  = (w_reg[2] == '0);
    end

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQ:
            begin
                mul_a = MA'(vec_reg[cmd.idx]);
                mul_b = MB'(vec_reg[cmd.idx]);
            end
            OP_CROSS_A:
            begin
                mul_a = MA'(rot_reg[4'd6 + {2'b00, ci}]);
                mul_b = MB'(rot_reg[{2'b00, cj}]);
            end
            OP_CROSS_B:
            begin
                mul_a = MA'(rot_reg[4'd6 + {2'b00, cj}]);
                mul_b = MB'(rot_reg[{2'b00, ci}]);
            end
            OP_MAC:
            begin
                mul_a = MA'(rot_reg[rix]);
                mul_b = MB'(v_vec[cmd.idx]);
            end
            OP_DIV_PROJ_START:
            begin
                mul_a = MA'($signed({1'b0, floor_height}));
                mul_b = MB'($signed({1'b0, wk_mag}));
            end
            default:
            begin
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Rounding of the accumulator by F bits, half away from zero
    always_comb
    begin
        acc_mag   = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        rnd_mag   = (acc_mag + (AW'(1) << (F - 1))) >> F;
        clamp_mag = (rnd_mag > (AW'(1) << F)) ? (AW'(1) << F) : rnd_mag;
    end

    // Square root and divider steps
    always_comb
    begin
        sq_rb = sq_r_reg + sq_b_reg;
        trial = {rem_reg, num_reg[NUMW-1]};
        ge    = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    // Unit vector entry from the quotient
    always_comb
    begin
        unit_t   = (quo_reg > (NUMW'(1) << F)) ? (NUMW'(1) << F) : quo_reg;
        unit_val = vec_reg[cmd.idx][D_W-1] ? -RW'(unit_t) : RW'(unit_t);
    end

    // Ground coordinate with saturation
    always_comb
    begin
        proj_neg = w_reg[cmd.idx][W_W-1] ^ w_reg[2][W_W-1];
        if (horizon)
        begin
            if (w_reg[cmd.idx] == '0 || floor_height == '0)
                proj_val = '0;
            else if (w_reg[cmd.idx][W_W-1])
                proj_val = 32'sh8000_0000;
            else
                proj_val = 32'sh7fff_ffff;
        end
        else if (!proj_neg)
        begin
            if (quo_reg > NUMW'(32'h7fff_ffff))
                proj_val = 32'sh7fff_ffff;
            else
                proj_val = quo_reg[31:0];
        end
        else
        begin
            if (quo_reg > NUMW'(33'h1_0000_0000 >> 1))
                proj_val = 32'sh8000_0000;
            else
                proj_val = -quo_reg[31:0];
        end
    end

    // Matrix, square root and divider control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                rot_reg[i] <= (i % 4 == 0) ? ROT_ONE : '0;
            sq_b_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_SQRT_START:
                    sq_b_reg <= SQ_N_W'(1) << (SQ_N_W - 2);
                OP_SQRT_STEP:
                    sq_b_reg <= sq_b_reg >> 2;
                OP_DIV_UNIT_START, OP_DIV_PROJ_START:
                    cnt_reg <= CW'(NUMW);
                OP_DIV_STEP:
                    cnt_reg <= cnt_reg - 1'b1;
                OP_UNIT_WRITE:
                    rot_reg[rix] <= unit_val;
                OP_FALLBACK:
                    for (int e = 0; e < 3; e++)
                        rot_reg[{2'b00, cmd.row} * 4'd3 + 4'(e)] <=
                            (e == ((cmd.row == 2'd2) ? 2 : 0)) ? ROT_ONE : '0;
                OP_CROSS_WRITE:
                    rot_reg[4'd3 + {2'b00, cmd.idx}] <= acc_reg[AW-1]
                        ? -RW'(clamp_mag) : RW'(clamp_mag);
                default:
                begin
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD_ACCEL:
            begin
                d_reg[0]   <= $signed({1'b0, accel_x}) - $signed({1'b0, accel_zero});
                d_reg[1]   <= $signed({1'b0, accel_y}) - $signed({1'b0, accel_zero});
                d_reg[2]   <= $signed({1'b0, accel_z}) - $signed({1'b0, accel_zero});
                vec_reg[0] <= $signed({1'b0, accel_x}) - $signed({1'b0, accel_zero});
                vec_reg[1] <= $signed({1'b0, accel_y}) - $signed({1'b0, accel_zero});
                vec_reg[2] <= $signed({1'b0, accel_z}) - $signed({1'b0, accel_zero});
            end
            OP_LOAD_POINT:
            begin
                px_reg <= pixel_x;
                py_reg <= pixel_y;
            end
            OP_SIDE_LOAD:
            begin
                vec_reg[0] <= d_reg[2];
                vec_reg[1] <= '0;
                vec_reg[2] <= -d_reg[1];
            end
            OP_SQ, OP_MAC:
                acc_reg <= ((cmd.idx == 2'd0) ? AW'(0) : acc_reg) + AW'(prod);
            OP_CROSS_A:
                acc_reg <= AW'(prod);
            OP_CROSS_B:
                acc_reg <= acc_reg - AW'(prod);
            OP_SQRT_START:
            begin
                sq_n_reg <= SQ_N_W'(acc_reg[SUM_W-1:0]) << SQ_SHIFT;
                sq_r_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                if (sq_n_reg >= sq_rb)
                begin
                    sq_n_reg <= sq_n_reg - sq_rb;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
            end
            OP_DIV_UNIT_START:
            begin
                num_reg <= (NUMW'(vec_mag[7:0]) << (F + 16))
                         + NUMW'(sq_r_reg[L_W-1:0] >> 1);
                den_reg <= DEN_W'(sq_r_reg[L_W-1:0]);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_DIV_PROJ_START:
            begin
                num_reg <= (NUMW'(prod) << O) + NUMW'(proj_den >> 1);
                den_reg <= proj_den;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                num_reg <= num_reg << 1;
                quo_reg <= {quo_reg[NUMW-2:0], ge};
                rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            end
            OP_W_WRITE:
                w_reg[cmd.row] <= acc_reg[AW-1] ? -W_W'(rnd_mag) : W_W'(rnd_mag);
            OP_PROJ_WRITE:
            begin
                if (cmd.idx == 2'd0)
                    gx_reg <= proj_val;
                else
                    gy_reg <= proj_val;
            end
            default:
            begin
            end
        endcase
    end

    // Status and results
    assign stat.sum_zero  = (acc_reg == '0);
    assign stat.sqrt_busy = (sq_b_reg != '0);
    assign stat.div_busy  = (cnt_reg != '0);
    assign stat.horizon   = horizon;
    assign ground_x       = gx_reg;
    assign ground_y       = gy_reg;
    assign at_horizon     = horizon;

endmodule

// ===== hdl/tcfp_ctrl.sv =====
// ============================================================================
// Tilt-compensated floor projection: controller
// Sequences the datapath through normalization, cross product, rotation
// and projection, and hands finished results to the output register.
// ============================================================================
module tcfp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                item_cmd,
    input  logic                point_valid,
    input  tcfp_pkg::dp_stat_t  stat,
    input  logic                out_free,
    output logic                s_tready,
    output tcfp_pkg::dp_cmd_t   cmd,
    output logic                result_load
);
    import tcfp_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] row_reg, row_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            row_reg   <= row_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        row_next    = row_reg;
        cmd.op      = OP_NONE;
        cmd.idx     = idx_reg;
        cmd.row     = row_reg;
        s_tready    = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                idx_next = '0;
                if (s_tvalid)
                begin
                    if (item_cmd == CMD_ACCEL)
                    begin
                        cmd.op     = OP_LOAD_ACCEL;
                        row_next   = 2'd2;
                        state_next = ST_SQ;
                    end
                    else if (point_valid)
                    begin
                        cmd.op     = OP_LOAD_POINT;
                        row_next   = 2'd0;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_SQ:
            begin
                cmd.op = OP_SQ;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = ST_SQRT_START;
                end
                else
                    idx_next = idx_reg + 2'd1;
            end
            ST_SQRT_START:
            begin
                if (stat.sum_zero)
                    state_next = ST_FALLBACK;
                else
                begin
                    cmd.op     = OP_SQRT_START;
                    state_next = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (stat.sqrt_busy)
                    cmd.op = OP_SQRT_STEP;
                else
                    state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.op     = OP_DIV_UNIT_START;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_busy)
                    cmd.op = OP_DIV_STEP;
                else
                    state_next = ST_UNIT_WRITE;
            end
            ST_UNIT_WRITE, ST_FALLBACK:
            begin
                cmd.op = (state_reg == ST_FALLBACK) ? OP_FALLBACK : OP_UNIT_WRITE;
                if (idx_reg == 2'd2 || state_reg == ST_FALLBACK)
                begin
                    idx_next = '0;
                    if (row_reg == 2'd2)
                        state_next = ST_SIDE_LOAD;
                    else
                        state_next = ST_CROSS_A;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DIV_START;
                end
            end
            ST_SIDE_LOAD:
            begin
                cmd.op     = OP_SIDE_LOAD;
                row_next   = 2'd0;
                idx_next   = '0;
                state_next = ST_SQ;
            end
            ST_CROSS_A:
            begin
                cmd.op     = OP_CROSS_A;
                state_next = ST_CROSS_B;
            end
            ST_CROSS_B:
            begin
                cmd.op     = OP_CROSS_B;
                state_next = ST_CROSS_WRITE;
            end
            ST_CROSS_WRITE:
            begin
                cmd.op = OP_CROSS_WRITE;
                if (idx_reg == 2'd2)
                    state_next = ST_IDLE;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_CROSS_A;
                end
            end
            ST_MAC:
            begin
                cmd.op = OP_MAC;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = ST_W_WRITE;
                end
                else
                    idx_next = idx_reg + 2'd1;
            end
            ST_W_WRITE:
            begin
                cmd.op = OP_W_WRITE;
                if (row_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = ST_PROJ_START;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = ST_MAC;
                end
            end
            ST_PROJ_START:
            begin
                if (stat.horizon)
                    state_next = ST_PROJ_WRITE;
                else
                begin
                    cmd.op     = OP_DIV_PROJ_START;
                    state_next = ST_PROJ_WAIT;
                end
            end
            ST_PROJ_WAIT:
            begin
                if (stat.div_busy)
                    cmd.op = OP_DIV_STEP;
                else
                    state_next = ST_PROJ_WRITE;
            end
            ST_PROJ_WRITE:
            begin
                cmd.op = OP_PROJ_WRITE;
                if (idx_reg == 2'd1)
                    state_next = ST_OUT;
                else
                begin
                    idx_next   = 2'd1;
                    state_next = ST_PROJ_START;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/tilt_compensated_floor_projection.sv =====
// ============================================================================
// Tilt-compensated floor projection
// Keeps a rotation matrix from accelerometer samples and projects IR camera
// points onto the floor at the configured camera height.
// ============================================================================
// An accelerometer transaction (tuser bit 0 low) rebuilds the rotation matrix
// and gives no result; it finishes sooner when a vector is zero. A valid IR
// point transaction gives one result; an invalid point is dropped at once.
// The shared divider is max(ROT_FRAC_BITS+25, OUT_FRAC_BITS+45)+1 bits long
// (54 at the defaults) and, bit-serial at one quotient bit per cycle, it
// sets most of the processing time.
// One transaction is processed at a time; the finished result waits in the
// output register, so the next transaction is taken while it is pending.
module tilt_compensated_floor_projection #(
    parameter int ROT_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // accel_x[7:0], accel_y[15:8], accel_z[23:16], pixel_x[33:24],
    // pixel_y[43:34], zero fill [47:44]
    input  logic [47:0]                   s_tdata,
    // cmd[0], point_valid[1]
    input  logic [1:0]                    s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ground_x[31:0], ground_y[63:32]
    output logic [63:0]                   m_tdata,
    // at_horizon[0]
    output logic                          m_tuser,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcfp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tcfp_pkg::*;

    logic [15:0]        floor_height_reg;
    logic [7:0]         accel_zero_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;
    logic               m_tuser_reg;
    dp_cmd_t            dp_cmd;
    dp_stat_t           dp_stat;
    logic               result_load;
    logic               out_free;
    logic signed [31:0] ground_x;
    logic signed [31:0] ground_y;
    logic               at_horizon;
    logic               cfg_write;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_height_reg <= FH_RESET;
            accel_zero_reg   <= AZ_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr == ADDR_FLOOR_HEIGHT)
                floor_height_reg <= pwdata[15:0];
            else if (paddr == ADDR_ACCEL_ZERO)
                accel_zero_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr == ADDR_FLOOR_HEIGHT)
            prdata = {16'b0, floor_height_reg};
        else if (paddr == ADDR_ACCEL_ZERO)
            prdata = {24'b0, accel_zero_reg};
        else
            prdata = '0;
    end

    // Controller
    tcfp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .item_cmd    (s_tuser[0]),
        .point_valid (s_tuser[1]),
        .stat        (dp_stat),
        .out_free    (out_free),
        .s_tready    (s_tready),
        .cmd         (dp_cmd),
        .result_load (result_load)
    );

    // Datapath
    tcfp_datapath #(
        .ROT_FRAC_BITS (ROT_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .accel_x      (s_tdata[7:0]),
        .accel_y      (s_tdata[15:8]),
        .accel_z      (s_tdata[23:16]),
        .pixel_x      (s_tdata[33:24]),
        .pixel_y      (s_tdata[43:34]),
        .floor_height (floor_height_reg),
        .accel_zero   (accel_zero_reg),
        .stat         (dp_stat),
        .ground_x     (ground_x),
        .ground_y     (ground_y),
        .at_horizon   (at_horizon)
    );

    // Output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (result_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            m_tdata_reg <= {ground_y, ground_x};
            m_tuser_reg <= at_horizon;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/tcfp_checker.sv =====
// ============================================================================
// Tilt-compensated floor projection: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ============================================================================
module tcfp_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        pready
);

    // A pending result holds until its transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // An accelerometer transaction never yields a result right away.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> !$rose(m_tvalid))
    else $error("result raised after accelerometer transaction");

    // Work that starts processing blocks the input for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (!s_tuser[0] || s_tuser[1]) |=> !s_tready)
    else $error("input accepted while busy");

    // A horizon result carries a saturated or zero ground x.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[31:0] == 32'h7fff_ffff
            || m_tdata[31:0] == 32'h8000_0000 || m_tdata[31:0] == 32'h0))
    else $error("horizon result not saturated");

    // The configuration port never waits.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port stalled");

endmodule

bind tilt_compensated_floor_projection tcfp_port_checks u_tcfp_port_checks (.*);

// ===== bench/tcfp_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Floor projection result checker
// Watches the input and result streams and the register writes, keeps its
// own copy of the rotation matrix and registers, computes the expected floor
// coordinates of every valid IR point and compares them with the results.
// ============================================================================
module tcfp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [tcfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    import tcfp_pkg::*;

    localparam int RF = 14;
    localparam int OF = 8;
    localparam longint ONE = 64'sd1 <<< RF;
    localparam longint CAM_K = 64'sd93920134;

    typedef struct {
        logic [31:0] gx;
        logic [31:0] gy;
        logic        hz;
    } ground_t;

    longint      rot [9];
    logic [15:0] height;
    logic [7:0]  zero_raw;
    ground_t     ground_q[$];

    assign pending = ground_q.size();

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint shift_round(longint v, int k);
        longint unsigned m;
        m = absval(v);
        m = (m + (64'd1 << (k - 1))) >> k;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    // Normalize a vector; returns zero when the vector has no length.
    function automatic bit normalize(input longint c [3], output longint q [3]);
        longint unsigned s, len, t;
        s = 0;
        for (int i = 0; i < 3; i++) s += absval(c[i]) * absval(c[i]);
        for (int i = 0; i < 3; i++) q[i] = 0;
        if (s == 0) return 0;
        len = int_sqrt(s << 32);
        for (int i = 0; i < 3; i++)
        begin
            t = ((absval(c[i]) << (RF + 16)) + len / 2) / len;
            if (t > ONE) t = ONE;
            q[i] = c[i] < 0 ? -longint'(t) : longint'(t);
        end
        return 1;
    endfunction

    function automatic longint floor_coord(longint w, longint den, bit hz);
        longint unsigned num, d, q;
        bit neg;
        num = absval(w) * height;
        neg = w < 0;
        if (hz)
        begin
            if (num == 0) return 0;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        if (den < 0) neg = !neg;
        num <<= OF;
        d = absval(den) << 8;
        q = (num + d / 2) / d;
        if (!neg) return q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
        if (q > 64'd2147483648) return -64'sd2147483648;
        return -longint'(q);
    endfunction

    // Rebuild the rotation matrix from one accelerometer sample.
    task automatic update_rotation(logic [47:0] data);
        longint d [3];
        longint c [3];
        longint dn [3];
        longint sd [3];
        for (int i = 0; i < 3; i++)
            d[i] = longint'(data[8*i +: 8]) - longint'(zero_raw);
        if (!normalize(d, dn))
            dn = '{0, 0, ONE};
        c = '{d[2], 0, -d[1]};
        if (!normalize(c, sd))
            sd = '{ONE, 0, 0};
        for (int i = 0; i < 3; i++)
        begin
            rot[i] = sd[i];
            rot[6 + i] = dn[i];
        end
        rot[3] = clamp_one(shift_round(dn[1] * sd[2] - dn[2] * sd[1], RF));
        rot[4] = clamp_one(shift_round(dn[2] * sd[0] - dn[0] * sd[2], RF));
        rot[5] = clamp_one(shift_round(dn[0] * sd[1] - dn[1] * sd[0], RF));
    endtask

    function automatic ground_t project_point(logic [47:0] data);
        longint v [3];
        longint w [3];
        ground_t g;
        v[0] = (64'sd512 - longint'(data[33:24])) * 65536;
        v[1] = -CAM_K;
        v[2] = (longint'(data[43:34]) - 64'sd384) * 65536;
        for (int i = 0; i < 3; i++)
            w[i] = shift_round(rot[3*i] * v[0] + rot[3*i+1] * v[1] + rot[3*i+2] * v[2], RF);
        g.hz = (w[2] == 0);
        g.gx = 32'(floor_coord(w[0], w[2], g.hz));
        g.gy = 32'(floor_coord(w[1], w[2], g.hz));
        return g;
    endfunction

    // Track registers and inputs, and check each result transaction.
    always @(posedge clk or negedge rst_n)
    begin
        ground_t g;
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? ONE : 0;
            height = FH_RESET;
            zero_raw = AZ_RESET;
            ground_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_FLOOR_HEIGHT) height = pwdata[15:0];
                else if (paddr == ADDR_ACCEL_ZERO) zero_raw = pwdata[7:0];
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == CMD_ACCEL)
                    update_rotation(s_tdata);
                else if (s_tuser[1])
                    ground_q.push_back(project_point(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                if (ground_q.size() == 0)
                begin
                    $display("%0t: unexpected result gx=%h gy=%h hz=%b", $time,
                             m_tdata[31:0], m_tdata[63:32], m_tuser);
                    fail_count++;
                end
                else
                begin
                    g = ground_q.pop_front();
                    if (m_tdata[31:0] !== g.gx || m_tdata[63:32] !== g.gy
                        || m_tuser !== g.hz)
                    begin
                        $display("%0t: expected gx=%h gy=%h hz=%b, got gx=%h gy=%h hz=%b",
                                 $time, g.gx, g.gy, g.hz, m_tdata[31:0],
                                 m_tdata[63:32], m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/tilt_compensated_floor_projection_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Floor projection testbench
// Drives accelerometer samples and IR points with random gaps and stalls
// through several register settings; the checker compares every result.
// ============================================================================
module tilt_compensated_floor_projection_tb;
    import tcfp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          hold_sink;

    tilt_compensated_floor_projection dut (.*);

    tcfp_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, and one long hold-off.
    initial
    begin
        int n;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_tready <= 0;
                repeat (3000) @(negedge clk);
                hold_sink = 0;
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (n > 0)
            begin
                m_tready <= 0;
                repeat (n - 1) @(negedge clk);
                @(negedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] value);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one item, with a random leading gap when gaps is set; waits for acceptance.
    task automatic send(bit kind, bit ok, logic [7:0] ax, logic [7:0] ay,
                        logic [7:0] az, logic [9:0] px, logic [9:0] py,
                        bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 18) : 0;
        if (n > 0)
        begin
            s_tvalid <= 0;
            repeat (n) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {4'h0, py, px, az, ay, ax};
        s_tuser  <= {ok, kind};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_accel(logic [7:0] ax, logic [7:0] ay, logic [7:0] az, bit gaps);
        send(CMD_ACCEL, 1'($urandom_range(0, 1)), ax, ay, az,
             10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), gaps);
    endtask

    task automatic send_point(logic [9:0] px, logic [9:0] py, bit ok, bit gaps);
        send(CMD_POINT, ok, 8'($urandom), 8'($urandom), 8'($urandom), px, py, gaps);
    endtask

    // Let the block finish all work before a register change.
    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic random_phase(int count, bit gaps);
        int az;
        az = checker_i.zero_raw;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1: send_accel(8'($urandom), 8'($urandom), 8'($urandom), gaps);
                2: send_accel(8'(az + $urandom_range(0, 6) - 3),
                              8'(az + $urandom_range(0, 6) - 3),
                              8'($urandom), gaps);
                3: send_point(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                              1'b0, gaps);
                default: send_point(10'($urandom_range(0, 1023)),
                                    10'($urandom_range(0, 1023)), 1'b1, gaps);
            endcase
        end
    endtask

    initial
    begin
        logic [15:0] heights [5];
        logic [7:0]  zeros [5];
        s_tvalid = 0; s_tdata = '0; s_tuser = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        hold_sink = 0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: identity matrix, corners of the sensor, horizon row.
        send_point(10'd512, 10'd384, 1'b1, 1'b0);
        send_point(10'd0, 10'd0, 1'b1, 1'b0);
        send_point(10'd1023, 10'd1023, 1'b1, 1'b0);
        send_point(10'd1023, 10'd767, 1'b0, 1'b0);
        send_accel(8'd118, 8'd118, 8'd118, 1'b0);     // zero vector: fallback axes
        send_point(10'd300, 10'd700, 1'b1, 1'b0);
        send_accel(8'd255, 8'd118, 8'd118, 1'b0);     // down along x: side fallback
        send_point(10'd0, 10'd384, 1'b1, 1'b0);
        send_point(10'd512, 10'd384, 1'b1, 1'b0);     // along side axis: horizon
        send_accel(8'd0, 8'd0, 8'd0, 1'b0);
        send_point(10'd1023, 10'd0, 1'b1, 1'b0);
        send_accel(8'd255, 8'd255, 8'd255, 1'b0);
        send_point(10'd512, 10'd767, 1'b1, 1'b0);
        send_accel(8'd118, 8'd0, 8'd118, 1'b0);
        send_point(10'd512, 10'd384, 1'b1, 1'b0);
        send_accel(8'd118, 8'd118, 8'd255, 1'b0);
        send_point(10'd100, 10'd200, 1'b1, 1'b0);
        drain();

        heights = '{16'd1, 16'd65535, 16'd0, 16'd256, 16'd5000};
        zeros   = '{8'd0, 8'd255, 8'd118, 8'd128, 8'd90};
        for (int p = 0; p < 5; p++)
        begin
            reg_write(ADDR_FLOOR_HEIGHT, {16'h0, heights[p]});
            reg_write(ADDR_ACCEL_ZERO, {24'h0, zeros[p]});
            if (p == 1)
            begin
                // Long receiver hold-off while points keep coming.
                hold_sink = 1;
                for (int i = 0; i < 8; i++)
                    send_point(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 767)),
                               1'b1, 1'b0);
            end
            random_phase(400, p != 3);
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/tcfp_pkg.sv
hdl/tcfp_datapath.sv
hdl/tcfp_ctrl.sv
hdl/tilt_compensated_floor_projection.sv
hdl/tcfp_checker.sv
bench/tcfp_checker.sv
bench/tilt_compensated_floor_projection_tb.sv
